FILE: rtl/core/cbpe_pkg.sv
// Package for the cubic Bezier point evaluator: default widths and lane counts.
// Used by cubic_bezier_point_eval_top; depends on nothing else.
package cbpe_pkg;

   localparam int COORD_BITS_DEF  = 10;
   localparam int T_FRAC_BITS_DEF = 10;

   localparam int NUM_AXES = 2;
   localparam int AXIS_X   = 0;
   localparam int AXIS_Y   = 1;

endpackage

FILE: rtl/core/cubic_bezier_point_eval_top.sv
// Cubic Bezier point evaluator, five register stages, one word per cycle unless stalled.
// Depends on cbpe_pkg for default widths and axis numbering.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | p0..p3 x/y, t_step
//   rsp     | out       | rsp_valid/rsp_stall | curve_x, curve_y
//
// A word passes through stages 1 to 5 in order, and one word can enter in every cycle unless stalled.
// The pipeline depth is set by the input stage, the two chained multiplier stages and the two adder stages.
// All stages advance together; a stalled result freezes the whole pipeline.
// Reset clears the valid bits of every stage; data registers are not reset.
module cubic_bezier_point_eval_top #(
   parameter int COORD_BITS  = cbpe_pkg::COORD_BITS_DEF,
   parameter int T_FRAC_BITS = cbpe_pkg::T_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COORD_BITS-1:0]  req_p0_x,
   input  logic [COORD_BITS-1:0]  req_p0_y,
   input  logic [COORD_BITS-1:0]  req_p1_x,
   input  logic [COORD_BITS-1:0]  req_p1_y,
   input  logic [COORD_BITS-1:0]  req_p2_x,
   input  logic [COORD_BITS-1:0]  req_p2_y,
   input  logic [COORD_BITS-1:0]  req_p3_x,
   input  logic [COORD_BITS-1:0]  req_p3_y,
   input  logic [T_FRAC_BITS:0]   req_t_step,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_BITS-1:0]  rsp_curve_x,
   output logic [COORD_BITS-1:0]  rsp_curve_y
);

   import cbpe_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int TB  = T_FRAC_BITS + 1;
   localparam int AW  = CB + TB;
   localparam int SW  = 2 * TB;
   localparam int MW  = CB + 3 * TB;
   localparam int NW  = MW + 2;
   localparam int SHR = 3 * T_FRAC_BITS;

   localparam logic [TB-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   typedef logic [CB-1:0] coord_type;

   logic en;

   // Stage 1: clamped parameter and its complement.
   logic            v1_ff;
   logic [TB-1:0]   k1_ff, k1_in;
   logic [TB-1:0]   s1_ff, s1_in;
   coord_type       a1_ff [NUM_AXES];
   coord_type       b1_ff [NUM_AXES];
   coord_type       c1_ff [NUM_AXES];
   coord_type       d1_ff [NUM_AXES];

   // Stage 2: first products.
   logic            v2_ff;
   logic [SW-1:0]   ss2_ff, ss2_in;
   logic [SW-1:0]   sk2_ff, sk2_in;
   logic [SW-1:0]   kk2_ff, kk2_in;
   logic [AW-1:0]   as2_ff [NUM_AXES];
   logic [AW-1:0]   as2_in [NUM_AXES];
   logic [AW-1:0]   bs2_ff [NUM_AXES];
   logic [AW-1:0]   bs2_in [NUM_AXES];
   logic [AW-1:0]   ck2_ff [NUM_AXES];
   logic [AW-1:0]   ck2_in [NUM_AXES];
   logic [AW-1:0]   dk2_ff [NUM_AXES];
   logic [AW-1:0]   dk2_in [NUM_AXES];

   // Stage 3: the four weighted terms.
   logic            v3_ff;
   logic [MW-1:0]   m0_ff [NUM_AXES];
   logic [MW-1:0]   m0_in [NUM_AXES];
   logic [MW-1:0]   m1_ff [NUM_AXES];
   logic [MW-1:0]   m1_in [NUM_AXES];
   logic [MW-1:0]   m2_ff [NUM_AXES];
   logic [MW-1:0]   m2_in [NUM_AXES];
   logic [MW-1:0]   m3_ff [NUM_AXES];
   logic [MW-1:0]   m3_in [NUM_AXES];

   // Stage 4: partial sums of the outer and inner terms.
   logic            v4_ff;
   logic [NW-1:0]   u4_ff [NUM_AXES];
   logic [NW-1:0]   u4_in [NUM_AXES];
   logic [NW-1:0]   w4_ff [NUM_AXES];
   logic [NW-1:0]   w4_in [NUM_AXES];

   // Stage 5: output register.
   logic            v5_ff;
   coord_type       r5_ff [NUM_AXES];
   coord_type       r5_in [NUM_AXES];
   logic [NW-1:0]   num5  [NUM_AXES];

   assign en        = !(v5_ff && rsp_stall);
   assign req_stall = !en;

   assign k1_in = (req_t_step > T_ONE) ? T_ONE : req_t_step;
   assign s1_in = T_ONE - k1_in;

   always_comb begin
      ss2_in = SW'(s1_ff) * SW'(s1_ff);
      sk2_in = SW'(s1_ff) * SW'(k1_ff);
      kk2_in = SW'(k1_ff) * SW'(k1_ff);
      for (int i = 0; i < NUM_AXES; i++) begin
         as2_in[i] = AW'(a1_ff[i]) * AW'(s1_ff);
         bs2_in[i] = AW'(b1_ff[i]) * AW'(s1_ff);
         ck2_in[i] = AW'(c1_ff[i]) * AW'(k1_ff);
         dk2_in[i] = AW'(d1_ff[i]) * AW'(k1_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         m0_in[i] = MW'(as2_ff[i]) * MW'(ss2_ff);
         m1_in[i] = MW'(bs2_ff[i]) * MW'(sk2_ff);
         m2_in[i] = MW'(ck2_ff[i]) * MW'(sk2_ff);
         m3_in[i] = MW'(dk2_ff[i]) * MW'(kk2_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         u4_in[i] = NW'(m0_ff[i]) + NW'(m3_ff[i]);
         w4_in[i] = NW'(m1_ff[i]) + NW'(m2_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         num5[i]  = u4_ff[i] + w4_ff[i] + {w4_ff[i][NW-2:0], 1'b0};
         r5_in[i] = num5[i][SHR +: CB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k1_ff         <= k1_in;
         s1_ff         <= s1_in;
         a1_ff[AXIS_X] <= req_p0_x;
         a1_ff[AXIS_Y] <= req_p0_y;
         b1_ff[AXIS_X] <= req_p1_x;
         b1_ff[AXIS_Y] <= req_p1_y;
         c1_ff[AXIS_X] <= req_p2_x;
         c1_ff[AXIS_Y] <= req_p2_y;
         d1_ff[AXIS_X] <= req_p3_x;
         d1_ff[AXIS_Y] <= req_p3_y;
         ss2_ff        <= ss2_in;
         sk2_ff        <= sk2_in;
         kk2_ff        <= kk2_in;
         for (int i = 0; i < NUM_AXES; i++) begin
            as2_ff[i] <= as2_in[i];
            bs2_ff[i] <= bs2_in[i];
            ck2_ff[i] <= ck2_in[i];
            dk2_ff[i] <= dk2_in[i];
            m0_ff[i]  <= m0_in[i];
            m1_ff[i]  <= m1_in[i];
            m2_ff[i]  <= m2_in[i];
            m3_ff[i]  <= m3_in[i];
            u4_ff[i]  <= u4_in[i];
            w4_ff[i]  <= w4_in[i];
            r5_ff[i]  <= r5_in[i];
         end
      end
   end

   assign rsp_valid   = v5_ff;
   assign rsp_curve_x = r5_ff[AXIS_X];
   assign rsp_curve_y = r5_ff[AXIS_Y];

   // After reset the output stage holds no word.
   a_reset_empty : assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("output valid after reset");

   // A word at the start of the curve comes out as the first control point.
   a_start_point : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_t_step == '0)
         ##1 !req_stall ##1 !req_stall ##1 !req_stall ##1 !req_stall
      |=> rsp_valid && rsp_curve_x == $past(req_p0_x, 5)
          && rsp_curve_y == $past(req_p0_y, 5))
      else $error("curve start differs from first control point");

   // A word at or beyond the end of the curve comes out as the last control point.
   a_end_point : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_t_step >= T_ONE)
         ##1 !req_stall ##1 !req_stall ##1 !req_stall ##1 !req_stall
      |=> rsp_valid && rsp_curve_x == $past(req_p3_x, 5)
          && rsp_curve_y == $past(req_p3_y, 5))
      else $error("curve end differs from last control point");

endmodule

FILE: verif/cubic_bezier_point_eval_top_tb.sv
// Testbench for cubic_bezier_point_eval_top: directed and random control points with
// random gaps, stalls and one long output hold-off, checked against an in-bench model.
// Depends on cbpe_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module cubic_bezier_point_eval_top_tb;

   localparam int CB = cbpe_pkg::COORD_BITS_DEF;
   localparam int TF = cbpe_pkg::T_FRAC_BITS_DEF;
   localparam int CMAX = (1 << CB) - 1;
   localparam int TONE = 1 << TF;
   localparam int TMAX = (1 << (TF + 1)) - 1;
   localparam int NUM_RANDOM = 1950;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AFTER = 300;

   typedef struct packed {
      logic [CB-1:0] p0_x;
      logic [CB-1:0] p0_y;
      logic [CB-1:0] p1_x;
      logic [CB-1:0] p1_y;
      logic [CB-1:0] p2_x;
      logic [CB-1:0] p2_y;
      logic [CB-1:0] p3_x;
      logic [CB-1:0] p3_y;
      logic [TF:0]   t_step;
   } bezier_req_type;

   typedef struct packed {
      logic [CB-1:0] x;
      logic [CB-1:0] y;
   } bezier_pt_type;

   class bezier_scoreboard;
      bezier_pt_type points_due[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      function logic [CB-1:0] axis_floor(logic [CB-1:0] a, logic [CB-1:0] b,
                                         logic [CB-1:0] c, logic [CB-1:0] d,
                                         logic [TF:0] t);
         longint unsigned k;
         longint unsigned s;
         longint unsigned num;
         k = (t > TONE) ? 64'(TONE) : 64'(t);
         s = 64'(TONE) - k;
         num = a * s * s * s + 64'd3 * b * s * s * k + 64'd3 * c * s * k * k
               + d * k * k * k;
         return CB'(num >> (3 * TF));
      endfunction

      function void note_request(bezier_req_type w);
         bezier_pt_type p;
         p.x = axis_floor(w.p0_x, w.p1_x, w.p2_x, w.p3_x, w.t_step);
         p.y = axis_floor(w.p0_y, w.p1_y, w.p2_y, w.p3_y, w.t_step);
         points_due.insert(points_due.size(), p);
      endfunction

      function void check_point(logic [CB-1:0] x, logic [CB-1:0] y);
         bezier_pt_type p;
         if (points_due.size() == 0) begin
            $display("%0t: unexpected point, got x %0d y %0d", $time, x, y);
            errors++;
            return;
         end
         p = points_due.pop_front();
         if (p.x !== x) begin
            $display("%0t: curve_x expected %0d, got %0d", $time, p.x, x);
            errors++;
         end
         if (p.y !== y) begin
            $display("%0t: curve_y expected %0d, got %0d", $time, p.y, y);
            errors++;
         end
      endfunction

      function int pending();
         return points_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [CB-1:0] req_p0_x, req_p0_y, req_p1_x, req_p1_y;
   logic [CB-1:0] req_p2_x, req_p2_y, req_p3_x, req_p3_y;
   logic [TF:0] req_t_step;
   logic rsp_valid;
   logic rsp_stall;
   logic [CB-1:0] rsp_curve_x;
   logic [CB-1:0] rsp_curve_y;

   bezier_scoreboard sb;
   int words_in;
   int words_out;
   int saturated_sent;
   bit held_off;

   cubic_bezier_point_eval_top #(
      .COORD_BITS(CB),
      .T_FRAC_BITS(TF)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_p0_x(req_p0_x),
      .req_p0_y(req_p0_y),
      .req_p1_x(req_p1_x),
      .req_p1_y(req_p1_y),
      .req_p2_x(req_p2_x),
      .req_p2_y(req_p2_y),
      .req_p3_x(req_p3_x),
      .req_p3_y(req_p3_y),
      .req_t_step(req_t_step),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_curve_x(rsp_curve_x),
      .rsp_curve_y(rsp_curve_y)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin : monitor
      bezier_req_type w;
      if (!reset && sb != null) begin
         if (req_valid && !req_stall) begin
            w = {req_p0_x, req_p0_y, req_p1_x, req_p1_y,
                 req_p2_x, req_p2_y, req_p3_x, req_p3_y, req_t_step};
            sb.note_request(w);
            words_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_point(rsp_curve_x, rsp_curve_y);
            words_out++;
         end
      end
   end

   task automatic send_word(bezier_req_type w);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_p0_x   <= w.p0_x;
      req_p0_y   <= w.p0_y;
      req_p1_x   <= w.p1_x;
      req_p1_y   <= w.p1_y;
      req_p2_x   <= w.p2_x;
      req_p2_y   <= w.p2_y;
      req_p3_x   <= w.p3_x;
      req_p3_y   <= w.p3_y;
      req_t_step <= w.t_step;
      if (w.t_step > TONE) saturated_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_req(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   function automatic logic [CB-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return CB'(CMAX);
         default: return CB'($urandom);
      endcase
   endfunction

   function automatic logic [TF:0] rand_t();
      case ($urandom_range(0, 9))
         7: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return (TF+1)'(1);
               2: return (TF+1)'(TONE - 1);
               default: return (TF+1)'(TONE);
            endcase
         end
         8, 9: return (TF+1)'($urandom_range(TONE + 1, TMAX));
         default: return (TF+1)'($urandom_range(0, TONE));
      endcase
   endfunction

   initial begin
      int run;
      bit level;
      rsp_stall = 1'b0;
      held_off = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held_off && words_in >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            repeat (HOLD_OFF_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            level = $urandom_range(0, 1);
            if (!level) run = $urandom_range(1, 40);
            else if ($urandom_range(0, 9) == 0) run = $urandom_range(20, 60);
            else run = $urandom_range(1, 3);
            repeat (run) begin
               @(negedge clock);
               rsp_stall <= level;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("[cubic_bezier_point_eval_top] ERROR");
      $finish;
   end

   initial begin
      bezier_req_type w;
      int gap;
      int r;
      sb = new();
      words_in = 0;
      words_out = 0;
      saturated_sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_p0_x, req_p0_y, req_p1_x, req_p1_y} = '0;
      {req_p2_x, req_p2_y, req_p3_x, req_p3_y} = '0;
      req_t_step = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_word('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, TONE});
      send_word('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0});
      send_word('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, TMAX});
      send_word('{0, 0, 0, 0, 0, 0, CMAX, CMAX, TONE});
      send_word('{0, 0, 0, 0, 0, 0, CMAX, CMAX, TONE - 1});
      send_word('{CMAX, CMAX, 0, 0, 0, 0, 0, 0, 0});
      send_word('{CMAX, CMAX, 0, 0, 0, 0, 0, 0, 1});
      send_word('{0, 0, CMAX, CMAX, CMAX, CMAX, 0, 0, TONE / 2});
      send_word('{0, CMAX, CMAX, 0, 0, CMAX, CMAX, 0, TONE / 2});
      send_word('{0, CMAX, CMAX, 0, 0, CMAX, CMAX, 0, TONE / 4});
      send_word('{0, CMAX, CMAX, 0, 0, CMAX, CMAX, 0, 3 * TONE / 4});
      send_word('{'h2AA, 'h155, 'h155, 'h2AA, 'h2AA, 'h155, 'h155, 'h2AA, TONE - 1});
      send_word('{'h155, 'h2AA, 'h2AA, 'h155, 'h155, 'h2AA, 'h2AA, 'h155, 1});
      send_word('{'h155, 'h2AA, 'h2AA, 'h155, 'h155, 'h2AA, 'h2AA, 'h155, TONE + 1});
      send_word('{10, 20, 500, 900, 900, 500, 37, 1000, 3 * TONE / 2});
      send_word('{1, 1, 1, 1, 1, 1, 1, 1, TONE / 3});
      send_word('{CMAX - 1, 0, 0, CMAX - 1, CMAX - 1, 0, 0, CMAX - 1, 'h555});
      send_word('{CMAX, 0, 0, CMAX, 0, CMAX, CMAX, 0, 'h2AA});
      idle_req(3);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         w.p0_x = rand_coord();
         w.p0_y = rand_coord();
         w.p1_x = rand_coord();
         w.p1_y = rand_coord();
         w.p2_x = rand_coord();
         w.p2_y = rand_coord();
         w.p3_x = rand_coord();
         w.p3_y = rand_coord();
         w.t_step = rand_t();
         send_word(w);
         r = $urandom_range(0, 99);
         if (i % 100 < 25 || r < 60) gap = 0;
         else if (r < 92) gap = $urandom_range(1, 3);
         else gap = $urandom_range(8, 40);
         if (gap > 0) idle_req(gap);
      end
      idle_req(1);

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d words in and %0d points out, %0d with t beyond one,",
               words_in, words_out, saturated_sent);
      $display("with random gaps and stalls and one output hold-off of %0d cycles.",
               HOLD_OFF_CYCLES);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[cubic_bezier_point_eval_top] OK");
      end else begin
         $display("[cubic_bezier_point_eval_top] ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/cbpe_pkg.sv
rtl/core/cubic_bezier_point_eval_top.sv
verif/cubic_bezier_point_eval_top_tb.sv
